FILE: sv/ordered_set_successor_table_defines.svh
// ----------------------------------------------------------------------------
// ordered_set_successor_table_defines.svh
// Assertion macros used by the successor table checker.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SET_SUCCESSOR_TABLE_DEFINES_SVH
`define ORDERED_SET_SUCCESSOR_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define OSST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define OSST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/osst_pkg.sv
// ----------------------------------------------------------------------------
// osst_pkg
// Types and defaults shared by the successor table controller and datapath.
// ----------------------------------------------------------------------------
package osst_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 30;

    // Command codes carried in tuser on the slave side
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_EVAL,
        ST_SH_RD,
        ST_SH_WR,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        RD_MID,
        RD_POS,
        RD_SHIFT
    } t_rd_sel;

    typedef struct packed {
        logic    load;       // capture item, open the search range
        logic    rd_en;      // table read
        t_rd_sel rd_sel;     // read address source
        logic    step;       // narrow the search range
        logic    eval;       // latch the pending result
        logic    shift_init; // shift pointer one past the last stored entry
        logic    shift_wr;   // move one entry up a slot
        logic    ins_wr;     // write new key at its place, bump count
        logic    out_load;   // move pending result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic range_open; // search range not yet empty
        logic go_insert;  // add of a new key with room left
        logic at_pos;     // shift pointer reached insert position
        logic out_free;   // output register can take a result
    } t_dp_stat;

endpackage

FILE: sv/osst_ctrl.sv
// ----------------------------------------------------------------------------
// osst_ctrl
// Sequencer for search, insert shift and result hand-off.
// ----------------------------------------------------------------------------
module osst_ctrl
    import osst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_cmd.rd_sel = RD_MID;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // no transfer taken while reset is held
                o_s_ready = i_rst_n;
                if (i_rst_n && i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                o_cmd.rd_en = 1'b1;
                if (i_stat.range_open) begin
                    o_cmd.rd_sel = RD_MID;
                    n_state      = ST_SRCH_CMP;
                end else begin
                    // range closed: fetch the entry at the lower bound
                    o_cmd.rd_sel = RD_POS;
                    n_state      = ST_EVAL;
                end
            end
            ST_SRCH_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = ST_SRCH_RD;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.go_insert) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = ST_SH_RD;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_SH_RD: begin
                if (i_stat.at_pos) begin
                    o_cmd.ins_wr = 1'b1;
                    n_state      = ST_RESULT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_SHIFT;
                    n_state      = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = ST_SH_RD;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/osst_dp.sv
// ----------------------------------------------------------------------------
// osst_dp
// Key table memory, search bounds, shift pointer and output register.
// ----------------------------------------------------------------------------
module osst_dp
    import osst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_in_cmd,
    input  logic [KEY_BITS-1:0] i_in_key,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_out_found,
    output logic                o_out_ovf,
    output logic [KEY_BITS-1:0] o_out_key
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    logic [KEY_BITS-1:0] mem [CAPACITY];

    logic [KEY_BITS-1:0] r_key;
    logic                r_cmd;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_count;
    logic [KEY_BITS-1:0] r_rdata;
    logic                r_res_found;
    logic                r_res_ovf;
    logic [KEY_BITS-1:0] r_res_key;
    logic                r_m_valid;
    logic                r_m_found;
    logic                r_m_ovf;
    logic [KEY_BITS-1:0] r_m_key;

    logic [CNT_W:0]      w_sum;
    logic [CNT_W-1:0]    w_mid;
    logic [CNT_W-1:0]    w_idx_m1;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic                w_pos_valid;
    logic                w_hit;
    logic                w_less;
    logic                w_full;

    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid       = w_sum[CNT_W:1];
    assign w_idx_m1    = r_idx - CNT_W'(1);
    assign w_pos_valid = (r_lo < r_count);
    assign w_hit       = (r_rdata == r_key);
    assign w_less      = (r_rdata < r_key);
    assign w_full      = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        case (i_cmd.rd_sel)
            RD_MID:   w_rd_addr = w_mid[ADDR_W-1:0];
            RD_POS:   w_rd_addr = r_lo[ADDR_W-1:0];
            RD_SHIFT: w_rd_addr = w_idx_m1[ADDR_W-1:0];
            default:  w_rd_addr = w_mid[ADDR_W-1:0];
        endcase
    end

    // Table: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
        if (i_cmd.shift_wr) begin
            mem[r_idx[ADDR_W-1:0]] <= r_rdata;
        end else if (i_cmd.ins_wr) begin
            mem[r_lo[ADDR_W-1:0]] <= r_key;
        end
    end

    // Item capture, search bounds and shift pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_in_key;
            r_cmd <= i_in_cmd;
            r_lo  <= '0;
            r_hi  <= r_count;
        end else if (i_cmd.step) begin
            if (w_less) begin
                r_lo <= w_mid + CNT_W'(1);
            end else begin
                r_hi <= w_mid;
            end
        end
        if (i_cmd.shift_init) begin
            r_idx <= r_count;
        end else if (i_cmd.shift_wr) begin
            r_idx <= w_idx_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_wr) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            if (r_cmd == CMD_QUERY) begin
                r_res_found <= w_pos_valid;
                r_res_ovf   <= 1'b0;
                r_res_key   <= w_pos_valid ? r_rdata : '0;
            end else begin
                r_res_found <= w_pos_valid && w_hit;
                r_res_ovf   <= !(w_pos_valid && w_hit) && w_full;
                r_res_key   <= '0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_found <= r_res_found;
            r_m_ovf   <= r_res_ovf;
            r_m_key   <= r_res_key;
        end
    end

    assign o_stat.range_open = (r_lo < r_hi);
    assign o_stat.go_insert  = (r_cmd == CMD_ADD) && !(w_pos_valid && w_hit) && !w_full;
    assign o_stat.at_pos     = (r_idx == r_lo);
    assign o_stat.out_free   = !r_m_valid || i_out_ready;

    assign o_out_valid = r_m_valid;
    assign o_out_found = r_m_found;
    assign o_out_ovf   = r_m_ovf;
    assign o_out_key   = r_m_key;

endmodule

FILE: sv/ordered_set_successor_table.sv
// ----------------------------------------------------------------------------
// ordered_set_successor_table
// Bounded sorted key set with insert and lower-bound (successor) lookup.
// ----------------------------------------------------------------------------
// Holds up to CAPACITY distinct keys in ascending order in a single-port-read,
// single-port-write table. Each slave transfer carries a command in tuser
// (0 = add, 1 = query) and a key in tdata; each one yields exactly one master
// transfer. A query returns the smallest stored key >= the input key with
// found set, or found clear and key 0 when none exists. An add of a key that
// is already present returns found set and leaves the table unchanged; an add
// of a new key to a full table is dropped and returns overflow set. One item
// is in flight at a time. Its cost is set by the binary search over the
// table; each probe takes a read state and a compare state because the
// table read is registered. An insert then moves every entry above the
// insert position up one slot, with a read state and a write state per
// entry, and ends with the write of the new key. The result sits in an
// output register, so the next item is taken while it waits. Reset empties
// the set at once; no clearing pass is needed since only entries below the
// count are read.
// ----------------------------------------------------------------------------
module ordered_set_successor_table
    import osst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((KEY_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // key, zero pad
    input  logic                                s_axis_tuser,  // cmd
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((KEY_BITS + 7) / 8) * 8-1:0] m_axis_tdata,  // result_key, zero pad
    output logic [1:0]                          m_axis_tuser   // found, overflow
);

    localparam int DATA_W = ((KEY_BITS + 7) / 8) * 8;

    t_dp_cmd             w_cmd;
    t_dp_stat            w_stat;
    logic                w_out_found;
    logic                w_out_ovf;
    logic [KEY_BITS-1:0] w_out_key;

    // Controller: owns the slave-side ready and sequences every transfer
    osst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // Datapath: key table, search bounds, result and output registers
    osst_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_cmd    (s_axis_tuser),
        .i_in_key    (s_axis_tdata[KEY_BITS-1:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_found (w_out_found),
        .o_out_ovf   (w_out_ovf),
        .o_out_key   (w_out_key)
    );

    assign m_axis_tdata = DATA_W'(w_out_key);
    assign m_axis_tuser = {w_out_ovf, w_out_found};

endmodule

FILE: sv/osst_checker.sv
// ----------------------------------------------------------------------------
// osst_checker
// Port-level checks on the successor table's result stream.
// ----------------------------------------------------------------------------
`include "ordered_set_successor_table_defines.svh"

module osst_checker
    import osst_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((KEY_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
    input logic [1:0]                          m_axis_tuser
);

    // a stalled result holds
    `OSST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // found and overflow exclude each other
    `OSST_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "found and overflow both set")

    // a non-zero key comes only with found
    `OSST_ASSERT_IMP(a_key_found, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[KEY_BITS-1:0] != '0), m_axis_tuser[0], "result key without found")

    // one item in flight: a transfer in is never followed at once by another
    `OSST_ASSERT_NXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

endmodule

bind ordered_set_successor_table osst_checker #(
    .KEY_BITS (KEY_BITS)
) u_osst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
